// ===== rtl/core/hvsi_pkg.sv =====
// Shared types, constants and arithmetic helpers for the HV setpoint interpolator.
package hvsi_pkg;

  localparam int CHANNELS            = 4;
  localparam int ENTRIES_PER_CHANNEL = 128;
  localparam int CH_W                = 2;
  localparam int ENTRY_W             = 7;
  localparam int IDX_W               = 9;
  localparam int WORD_W              = 16;
  localparam int VOLT_W              = 10;
  localparam int CFG_IDX_W           = 3;

  // accept edge to result strobe, in clock edges
  localparam int RESULT_DELAY = 7;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_EN  = 3'd4;

  localparam logic [15:0] COEF_RESET = 16'd1000;
  localparam logic [9:0]  MAX_RESET  = 10'd1023;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  channel;
    logic [6:0]  entry;
    logic [15:0] cal_word;
    logic [9:0]  tension;
    logic [15:0] slope;
  } req_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [15:0] setpoint;
    logic [15:0] increment;
    logic        from_table;
    logic        load_ack;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic        is_load;
    logic [1:0]  channel;
    logic [9:0]  tension;
    logic [15:0] slope;
    logic [15:0] coef;
    logic [9:0]  maxv;
    logic        use_table;
    logic [3:0]  frac;
    logic        d_zero;
  } issue_t;

  // floor(t / 10) for a 10-bit value
  function automatic logic [6:0] div10_u10(input logic [9:0] t);
    logic [17:0] p;
    p = 18'(t) * 18'd205;
    return p[17:11];
  endfunction

  // floor(x / 10) for a 21-bit value
  function automatic logic [17:0] div10_u21(input logic [20:0] x);
    logic [41:0] p;
    p = 42'(x) * 42'd1677722;
    return p[41:24];
  endfunction

  // floor(x / 1000) for a 32-bit value
  function automatic logic [22:0] div1000_u32(input logic [31:0] x);
    logic [60:0] p;
    p = 61'(x) * 61'd274877907;
    return p[60:38];
  endfunction

  function automatic logic [15:0] sat16_u23(input logic [22:0] x);
    return (x > 23'd65535) ? 16'hFFFF : x[15:0];
  endfunction

endpackage

// ===== rtl/core/hv_setpoint_interpolator_core.sv =====
// Top level: configuration registers, table access sequencing, result pipeline.
// A load word uses the table port once; a compute word uses it for both reads
// (low and high neighbor read from the single-port table), so busy is high
// for one cycle after a compute is accepted. Peak rate: one load per cycle;
// a compute blocks the next word while busy is high. done and rsp are registered
// at the end of the calculation pipeline; the receiver cannot stall.
// Sync reset restores register defaults.
module hv_setpoint_interpolator_core #(
  parameter int ENTRIES_PER_CHANNEL = hvsi_pkg::ENTRIES_PER_CHANNEL
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  hvsi_pkg::req_t                   req,
  output logic                             done,
  output hvsi_pkg::rsp_t                   rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hvsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data
);

  localparam int IW = $clog2(ENTRIES_PER_CHANNEL);
  localparam int AW = hvsi_pkg::CH_W + IW;
  localparam logic [hvsi_pkg::IDX_W-1:0] EPC = hvsi_pkg::IDX_W'(ENTRIES_PER_CHANNEL);

  logic [15:0] coef_low, coef_high;
  logic [9:0]  max_low, max_high;
  logic [3:0]  table_en;

  logic        accept;
  logic        second;
  logic [AW-1:0] hi_addr;

  logic [6:0]                  d;
  logic [hvsi_pkg::IDX_W-1:0] d9, dm1, lo_idx, hi_idx, entry9;
  logic [AW-1:0]               ram_addr;
  logic                        ram_we;
  logic [15:0]                 rdata;
  logic                        high_type;
  hvsi_pkg::issue_t            issue;

  assign cfg_ready = 1'b1;
  assign busy      = second;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_low  <= hvsi_pkg::COEF_RESET;
      coef_high <= hvsi_pkg::COEF_RESET;
      max_low   <= hvsi_pkg::MAX_RESET;
      max_high  <= hvsi_pkg::MAX_RESET;
      table_en  <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hvsi_pkg::CFG_COEF_LOW:  coef_low  <= cfg_data;
        hvsi_pkg::CFG_COEF_HIGH: coef_high <= cfg_data;
        hvsi_pkg::CFG_MAX_LOW:   max_low   <= cfg_data[9:0];
        hvsi_pkg::CFG_MAX_HIGH:  max_high  <= cfg_data[9:0];
        hvsi_pkg::CFG_TABLE_EN:  table_en  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    d      = hvsi_pkg::div10_u10(req.tension);
    d9     = hvsi_pkg::IDX_W'(d);
    dm1    = d9 - 9'd1;
    lo_idx = (dm1 >= EPC) ? EPC - 9'd1 : dm1;
    hi_idx = (d9 >= EPC) ? EPC - 9'd1 : d9;
    entry9 = hvsi_pkg::IDX_W'(req.entry);

    ram_we = accept && (req.cmd == hvsi_pkg::CMD_LOAD) && (entry9 < EPC);
    if (busy) begin
      ram_addr = hi_addr;
    end else if (req.cmd == hvsi_pkg::CMD_LOAD) begin
      ram_addr = {req.channel, entry9[IW-1:0]};
    end else begin
      ram_addr = {req.channel, lo_idx[IW-1:0]};
    end

    high_type       = req.channel[0];
    issue.valid     = accept;
    issue.is_load   = (req.cmd == hvsi_pkg::CMD_LOAD);
    issue.channel   = req.channel;
    issue.tension   = req.tension;
    issue.slope     = req.slope;
    issue.coef      = high_type ? coef_high : coef_low;
    issue.maxv      = high_type ? max_high : max_low;
    issue.use_table = table_en[req.channel] && !(high_type && (req.tension > max_high));
    issue.frac      = 4'(req.tension - 10'(d) * 10'd10);
    issue.d_zero    = (d == 7'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else begin
      second <= accept && (req.cmd == hvsi_pkg::CMD_COMPUTE);
    end
  end

  always_ff @(posedge clk) begin
    hi_addr <= {req.channel, hi_idx[IW-1:0]};
  end

  hvsi_cal_ram #(
    .AW(AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(req.cal_word),
    .rdata(rdata)
  );

  hvsi_calc u_calc (
    .clk  (clk),
    .rst  (rst),
    .issue(issue),
    .rdata(rdata),
    .done (done),
    .rsp  (rsp)
  );

endmodule

// ===== rtl/core/hvsi_cal_ram.sv =====
// Single-port calibration table memory with registered read data.
module hvsi_cal_ram #(
  parameter int AW = 9
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              addr,
  input  logic [hvsi_pkg::WORD_W-1:0] wdata,
  output logic [hvsi_pkg::WORD_W-1:0] rdata
);

  logic [hvsi_pkg::WORD_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/hvsi_calc.sv =====
// Setpoint arithmetic pipeline: interpolation, coefficient scaling, saturation.
module hvsi_calc (
  input  logic             clk,
  input  logic             rst,
  input  hvsi_pkg::issue_t issue,
  input  logic [15:0]      rdata,
  output logic             done,
  output hvsi_pkg::rsp_t   rsp
);

  typedef struct packed {
    logic       is_load;
    logic [1:0] ch;
    logic       use_table;
    logic       t_zero;
    logic       u_zero;
  } flags_t;

  logic [5:0] vld;

  flags_t      f1, f2, f3, f4, f5, f6;
  logic [9:0]  tension1;
  logic [15:0] slope1, coef1;
  logic [9:0]  max1;
  logic [3:0]  frac1, frac2, frac3;
  logic        dz1, dz2;

  logic [25:0] tc2, mc2, mc3, mc4, mc5, mc6;
  logic [31:0] sc2;
  logic [15:0] lo2, lo3, lo4, lo5;
  logic [15:0] hi3;
  logic [15:0] tq3, tq4, tq5, tq6, sq3, sq4, sq5, sq6;
  logic [20:0] num4;
  logic [17:0] qp5;
  logic [15:0] v6;

  logic signed [16:0] diff;
  logic signed [4:0]  frac_s;
  logic signed [21:0] prod;
  logic signed [21:0] num_off;
  logic signed [19:0] vs;
  logic [15:0]        v_interp;
  logic [15:0]        v_next;
  logic [25:0]        v_scaled;
  logic               tab;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[4:0], issue.valid};
      done <= vld[5];
    end
  end

  always_comb begin
    diff     = $signed({1'b0, hi3}) - $signed({1'b0, lo3});
    frac_s   = $signed({1'b0, frac3});
    prod     = 22'(diff) * 22'(frac_s);
    num_off  = prod + 22'sd655365;
    vs       = $signed({4'd0, lo5}) + $signed({2'd0, qp5}) - 20'sd65536;
    if (vs < 20'sd0) begin
      v_interp = 16'd0;
    end else if (vs > 20'sd65535) begin
      v_interp = 16'hFFFF;
    end else begin
      v_interp = vs[15:0];
    end
    if (f5.t_zero) begin
      v_next = 16'd0;
    end else if (f5.u_zero) begin
      v_next = lo5;
    end else begin
      v_next = v_interp;
    end
    v_scaled = 26'(v6) * 26'd1000;
    tab      = f6.use_table && (v_scaled <= mc6);
  end

  always_ff @(posedge clk) begin
    f1.is_load   <= issue.is_load;
    f1.ch        <= issue.channel;
    f1.use_table <= issue.use_table;
    f1.t_zero    <= (issue.tension == 10'd0);
    f1.u_zero    <= (issue.frac == 4'd0);
    tension1     <= issue.tension;
    slope1       <= issue.slope;
    coef1        <= issue.coef;
    max1         <= issue.maxv;
    frac1        <= issue.frac;
    dz1          <= issue.d_zero;

    f2    <= f1;
    tc2   <= 26'(tension1) * 26'(coef1);
    sc2   <= 32'(slope1) * 32'(coef1);
    mc2   <= 26'(max1) * 26'(coef1);
    lo2   <= rdata;
    frac2 <= frac1;
    dz2   <= dz1;

    f3    <= f2;
    tq3   <= hvsi_pkg::sat16_u23(hvsi_pkg::div1000_u32(32'(tc2)));
    sq3   <= hvsi_pkg::sat16_u23(hvsi_pkg::div1000_u32(sc2));
    mc3   <= mc2;
    lo3   <= dz2 ? 16'd0 : lo2;
    hi3   <= rdata;
    frac3 <= frac2;

    f4   <= f3;
    num4 <= num_off[20:0];
    lo4  <= lo3;
    tq4  <= tq3;
    sq4  <= sq3;
    mc4  <= mc3;

    f5  <= f4;
    qp5 <= hvsi_pkg::div10_u21(num4);
    lo5 <= lo4;
    tq5 <= tq4;
    sq5 <= sq4;
    mc5 <= mc4;

    f6  <= f5;
    v6  <= v_next;
    tq6 <= tq5;
    sq6 <= sq5;
    mc6 <= mc5;

    rsp.out_channel <= f6.ch;
    if (f6.is_load) begin
      rsp.setpoint   <= 16'd0;
      rsp.increment  <= 16'd0;
      rsp.from_table <= 1'b0;
      rsp.load_ack   <= 1'b1;
    end else begin
      rsp.setpoint   <= tab ? v6 : tq6;
      rsp.increment  <= sq6;
      rsp.from_table <= tab;
      rsp.load_ack   <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/hvsi_checker.sv =====
// Port-level checks for the HV setpoint interpolator, bound to the top level.
module hvsi_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input hvsi_pkg::req_t req,
  input logic           done,
  input hvsi_pkg::rsp_t rsp
);

  a_busy_after_compute: assert property (@(posedge clk) disable iff (rst)
    busy |-> $past(start && !busy && (req.cmd == hvsi_pkg::CMD_COMPUTE)))
    else $error("busy without an accepted compute word");

  a_busy_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(hvsi_pkg::RESULT_DELAY) done)
    else $error("accepted word produced no result");

  a_ack_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.load_ack == $past(req.cmd == hvsi_pkg::CMD_LOAD, hvsi_pkg::RESULT_DELAY))
             && (rsp.out_channel == $past(req.channel, hvsi_pkg::RESULT_DELAY)))
    else $error("result does not match its word");

  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.load_ack) |-> (rsp.setpoint == 16'd0) && (rsp.increment == 16'd0)
                               && !rsp.from_table)
    else $error("load acknowledge carries data");

endmodule

bind hv_setpoint_interpolator_core hvsi_checker u_hvsi_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .req  (req),
  .done (done),
  .rsp  (rsp)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the HV setpoint interpolator core: table loads, computes, config.
`timescale 1ns / 1ps

module tb_top;
  import hvsi_pkg::*;

  localparam int LIMIT = 200000;
  localparam int TABLE_WORDS = CHANNELS * ENTRIES_PER_CHANNEL;

  class setpoint_checker;
    logic [15:0] cal_mem [TABLE_WORDS];
    bit          written [TABLE_WORDS];
    logic [15:0] coef_low, coef_high;
    logic [9:0]  max_low, max_high;
    logic [3:0]  table_en;
    rsp_t        pending_rsp [$];
    int          mismatches, n_loads, n_computes, n_table_hits;

    function new();
      coef_low = COEF_RESET;
      coef_high = COEF_RESET;
      max_low = MAX_RESET;
      max_high = MAX_RESET;
      table_en = '0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
      case (idx)
        CFG_COEF_LOW:  coef_low = d;
        CFG_COEF_HIGH: coef_high = d;
        CFG_MAX_LOW:   max_low = d[9:0];
        CFG_MAX_HIGH:  max_high = d[9:0];
        CFG_TABLE_EN:  table_en = d[3:0];
        default: ;
      endcase
    endfunction

    function longint table_word(int ch, int i);
      if (i >= ENTRIES_PER_CHANNEL) i = ENTRIES_PER_CHANNEL - 1;
      return longint'(cal_mem[ch * ENTRIES_PER_CHANNEL + i]);
    endfunction

    function void note_request(req_t r);
      rsp_t   e;
      longint coef, maxv, v, lo, hv, num, q, inc;
      int     ch, d, u;
      bit     use_tab;
      e = '0;
      ch = int'(r.channel);
      e.out_channel = r.channel;
      if (r.cmd == CMD_LOAD) begin
        if (int'(r.entry) < ENTRIES_PER_CHANNEL) begin
          cal_mem[ch * ENTRIES_PER_CHANNEL + int'(r.entry)] = r.cal_word;
          written[ch * ENTRIES_PER_CHANNEL + int'(r.entry)] = 1'b1;
        end
        e.load_ack = 1'b1;
        n_loads++;
      end else begin
        coef = r.channel[0] ? longint'(coef_high) : longint'(coef_low);
        maxv = r.channel[0] ? longint'(max_high) : longint'(max_low);
        use_tab = table_en[ch];
        if (r.channel[0] && r.tension > max_high) use_tab = 1'b0;
        d = int'(r.tension) / 10;
        u = int'(r.tension) % 10;
        v = 0;
        if (use_tab) begin
          if (r.tension == 0) v = 0;
          else if (u == 0) v = table_word(ch, d - 1);
          else begin
            lo = (d == 0) ? 0 : table_word(ch, d - 1);
            hv = table_word(ch, d);
            num = (hv - lo) * u + 5;
            q = (num >= 0) ? num / 10 : -((-num + 9) / 10);
            v = lo + q;
            if (v < 0) v = 0;
          end
          if (v > maxv * coef / 1000) use_tab = 1'b0;
        end
        if (!use_tab) v = longint'(r.tension) * coef / 1000;
        inc = longint'(r.slope) * coef / 1000;
        e.setpoint = (v > 65535) ? 16'hFFFF : 16'(v);
        e.increment = (inc > 65535) ? 16'hFFFF : 16'(inc);
        e.from_table = use_tab;
        n_computes++;
        if (use_tab) n_table_hits++;
      end
      pending_rsp.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ch=%0d sp=%0d inc=%0d tab=%0b ack=%0b",
                   got.out_channel, got.setpoint, got.increment, got.from_table, got.load_ack);
        return;
      end
      e = pending_rsp.pop_front();
      if (got.out_channel !== e.out_channel || got.setpoint !== e.setpoint ||
          got.increment !== e.increment || got.from_table !== e.from_table ||
          got.load_ack !== e.load_ack) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp ch=%0d sp=%0d inc=%0d tab=%0b ack=%0b",
                   e.out_channel, e.setpoint, e.increment, e.from_table, e.load_ack);
          $display("          got ch=%0d sp=%0d inc=%0d tab=%0b ack=%0b",
                   got.out_channel, got.setpoint, got.increment, got.from_table, got.load_ack);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req = '0;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  setpoint_checker sb;
  int idle_pct = 0;
  int n_settings = 0;
  int cycles = 0;

  hv_setpoint_interpolator_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(rsp);
  end

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic issue_word(input req_t r);
    idle_gap();
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  task automatic load_word(input int ch, input int k, input logic [15:0] w);
    req_t r;
    r.cmd = CMD_LOAD;
    r.channel = 2'(ch);
    r.entry = 7'(k);
    r.cal_word = w;
    r.tension = 10'($urandom);
    r.slope = 16'($urandom);
    issue_word(r);
  endtask

  // roughly linear calibration with jitter, sometimes arbitrary
  function automatic logic [15:0] cal_code(input int ch, input int k);
    longint coef, v;
    coef = ch[0] ? longint'(sb.coef_high) : longint'(sb.coef_low);
    if ($urandom_range(7) == 0) return 16'($urandom);
    v = longint'((k + 1) * 10) * coef / 1000 + longint'($urandom_range(40)) - 20;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic compute_word(input int ch, input int t, input int s);
    req_t r;
    int   lo_i, hi_i;
    lo_i = (t / 10 > 0) ? t / 10 - 1 : 0;
    hi_i = (t / 10 > ENTRIES_PER_CHANNEL - 1) ? ENTRIES_PER_CHANNEL - 1 : t / 10;
    for (int i = lo_i; i <= hi_i; i++)
      if (!sb.written[ch * ENTRIES_PER_CHANNEL + i]) load_word(ch, i, cal_code(ch, i));
    r.cmd = CMD_COMPUTE;
    r.channel = 2'(ch);
    r.entry = 7'($urandom);
    r.cal_word = 16'($urandom);
    r.tension = 10'(t);
    r.slope = 16'(s);
    issue_word(r);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (RESULT_DELAY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  task automatic configure(input logic [15:0] c_lo, input logic [15:0] c_hi,
                           input logic [15:0] m_lo, input logic [15:0] m_hi,
                           input logic [15:0] en);
    settle();
    write_reg(CFG_COEF_LOW, c_lo);
    write_reg(CFG_COEF_HIGH, c_hi);
    write_reg(CFG_MAX_LOW, m_lo);
    write_reg(CFG_MAX_HIGH, m_hi);
    write_reg(CFG_TABLE_EN, en);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1000;
      default: return 16'($urandom_range(3000, 500));
    endcase
  endfunction

  function automatic logic [15:0] pick_max();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'd1023;
      default: return 16'($urandom_range(1023));
    endcase
  endfunction

  function automatic int pick_tension(input int ch);
    int m;
    m = ch[0] ? int'(sb.max_high) : int'(sb.max_low);
    case ($urandom_range(9))
      0: return 0;
      1: return 1023;
      2, 3: return 10 * $urandom_range(102);
      4: begin
        m = m + $urandom_range(4) - 2;
        return (m < 0) ? 0 : (m > 1023) ? 1023 : m;
      end
      5: return $urandom_range(9);
      default: return $urandom_range(1023);
    endcase
  endfunction

  function automatic int pick_slope();
    case ($urandom_range(7))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  initial begin
    int ch, k;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset values, exact and falling segments, discard, saturation
    load_word(0, 0, 16'd10);
    load_word(0, 1, 16'd5);
    load_word(0, 2, 16'hFFFF);
    load_word(1, 0, 16'd20);
    load_word(1, 1, 16'd0);
    load_word(3, 127, 16'hFFFF);
    load_word(2, 127, 16'd0);
    compute_word(0, 0, 0);
    compute_word(3, 1023, 65535);
    configure(16'd1000, 16'd1000, 16'd1023, 16'd1023, 16'hF);
    compute_word(0, 0, 1);
    compute_word(0, 5, 1000);
    compute_word(0, 10, 1);
    compute_word(0, 11, 2);
    compute_word(0, 15, 3);
    compute_word(0, 25, 4);
    compute_word(1, 5, 5);
    compute_word(1, 15, 6);
    configure(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hF);
    compute_word(0, 1023, 65535);
    compute_word(1, 5, 65535);
    compute_word(1, 0, 1);

    for (int p = 0; p < 8; p++) begin
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 53 : 6;
      configure(pick_coef(), pick_coef(), pick_max(), pick_max(),
                (p % 4 == 0) ? 16'hF : (p == 7) ? 16'h0 : 16'($urandom_range(15)));
      repeat (60) begin
        ch = $urandom_range(3);
        if ($urandom_range(9) < 3) begin
          k = $urandom_range(ENTRIES_PER_CHANNEL - 1);
          load_word(ch, k, cal_code(ch, k));
        end else begin
          compute_word(ch, pick_tension(ch), pick_slope());
        end
      end
    end

    settle();
    $display("summary: %0d loads, %0d computes, %0d taken from the table",
             sb.n_loads, sb.n_computes, sb.n_table_hits);
    $display("summary: %0d register settings, %0d mismatches, %0d results outstanding",
             n_settings, sb.mismatches, sb.pending_rsp.size());
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
